// File: sv/b64d_pkg.sv
// ============================================================================
// b64d_pkg
// Shared types, codes and the alphabet decode function for the base64
// stream decoder.
// ============================================================================
package b64d_pkg;

	// Status codes carried by each result.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_BAD_PAD  = 2'd2;
	localparam logic [1:0] ST_BAD_LEN  = 2'd3;

	// Decoder modes.
	localparam logic [1:0] MODE_NORMAL     = 2'd0;
	localparam logic [1:0] MODE_AWAIT_LAST = 2'd1;
	localparam logic [1:0] MODE_DROP       = 2'd2;

	// Character classes returned by the decode function.
	localparam logic [6:0] CLS_PAD     = 7'd64;
	localparam logic [6:0] CLS_INVALID = 7'd65;

	// Number of entries in the queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// One input character.
	typedef struct packed {
		logic [7:0] symbol;
		logic       final_symbol;
	} in_t;

	// One decoded result.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_output;
		logic [1:0] status;
	} out_t;

	// Results caused by one character, as one queue entry.
	// Entry k of data is result k; count is the number of results (1 to 3).
	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      count;
		logic            last;
		logic [1:0]      status;
	} group_t;

	// Maps a character to its six-bit value, or to the pad or invalid class.
	function automatic logic [6:0] classify(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			v = c - 8'h41;
			return {1'b0, v[5:0]};
		end else if (c inside {[8'h61:8'h7A]}) begin
			v = c - 8'h47;
			return {1'b0, v[5:0]};
		end else if (c inside {[8'h30:8'h39]}) begin
			v = c + 8'h04;
			return {1'b0, v[5:0]};
		end else if (c == 8'h2B) begin
			return 7'h3E;
		end else if (c == 8'h2F) begin
			return 7'h3F;
		end else if (c == 8'h3D) begin
			return CLS_PAD;
		end
		return CLS_INVALID;
	endfunction

endpackage

// File: sv/b64d_front.sv
// ============================================================================
// b64d_front
// Accepts characters, decodes them against the alphabet, tracks the quantum
// and error state, and pushes the results of each character as one group.
// ============================================================================
module b64d_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  b64d_pkg::in_t    in_data,
	output logic             push,
	output b64d_pkg::group_t push_group,
	input  logic             queue_full
);

	logic [17:0] acc_q;
	logic [1:0]  pos_q;
	logic [1:0]  mode_q;
	logic [7:0]  held_q;

	logic [17:0] acc_d;
	logic [1:0]  pos_d;
	logic [1:0]  mode_d;
	logic [7:0]  held_d;

	logic             accept;
	logic             last;
	logic [6:0]       cls;
	logic [23:0]      word;
	b64d_pkg::group_t grp;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign last     = in_data.final_symbol;
	assign cls      = b64d_pkg::classify(in_data.symbol);
	assign word     = {acc_q, cls[5:0]};

	// Next state and result group for the character at the input.
	always_comb begin
		acc_d  = acc_q;
		pos_d  = pos_q;
		mode_d = mode_q;
		held_d = held_q;
		grp    = '0;
		if (mode_q == b64d_pkg::MODE_DROP) begin
			if (last) begin
				acc_d  = '0;
				pos_d  = '0;
				mode_d = b64d_pkg::MODE_NORMAL;
				held_d = '0;
			end
		end else if (mode_q == b64d_pkg::MODE_AWAIT_LAST) begin
			acc_d  = '0;
			pos_d  = '0;
			held_d = '0;
			grp.count = 2'd1;
			grp.last  = 1'b1;
			if (last) begin
				grp.data[0] = held_q;
				grp.status  = b64d_pkg::ST_OK;
				mode_d      = b64d_pkg::MODE_NORMAL;
			end else begin
				grp.status = b64d_pkg::ST_BAD_PAD;
				mode_d     = b64d_pkg::MODE_DROP;
			end
		end else if ((last && pos_q != 2'd3) || cls == b64d_pkg::CLS_INVALID ||
				(cls == b64d_pkg::CLS_PAD && pos_q != 2'd2 && !(pos_q == 2'd3 && last))) begin
			// Error: one result, state cleared, drop the rest unless this is last.
			acc_d  = '0;
			pos_d  = '0;
			held_d = '0;
			mode_d = last ? b64d_pkg::MODE_NORMAL : b64d_pkg::MODE_DROP;
			grp.count = 2'd1;
			grp.last  = 1'b1;
			if (last && pos_q != 2'd3) begin
				grp.status = b64d_pkg::ST_BAD_LEN;
			end else if (cls == b64d_pkg::CLS_INVALID) begin
				grp.status = b64d_pkg::ST_BAD_CHAR;
			end else begin
				grp.status = b64d_pkg::ST_BAD_PAD;
			end
		end else if (cls == b64d_pkg::CLS_PAD && pos_q == 2'd2) begin
			// Pad in third position: hold one byte until the last character.
			held_d = acc_q[11:4];
			acc_d  = '0;
			pos_d  = '0;
			mode_d = b64d_pkg::MODE_AWAIT_LAST;
		end else if (cls == b64d_pkg::CLS_PAD) begin
			// Pad in fourth position on the last character: two bytes.
			grp.data[0] = acc_q[17:10];
			grp.data[1] = acc_q[9:2];
			grp.count   = 2'd2;
			grp.last    = 1'b1;
			grp.status  = b64d_pkg::ST_OK;
			acc_d  = '0;
			pos_d  = '0;
			mode_d = b64d_pkg::MODE_NORMAL;
			held_d = '0;
		end else if (pos_q == 2'd3) begin
			// Quantum complete: three bytes.
			grp.data[0] = word[23:16];
			grp.data[1] = word[15:8];
			grp.data[2] = word[7:0];
			grp.count   = 2'd3;
			grp.last    = last;
			grp.status  = b64d_pkg::ST_OK;
			acc_d = '0;
			pos_d = '0;
			if (last) begin
				mode_d = b64d_pkg::MODE_NORMAL;
				held_d = '0;
			end
		end else begin
			acc_d = word[17:0];
			pos_d = pos_q + 2'd1;
		end
	end

	assign push       = accept && (grp.count != 2'd0);
	assign push_group = grp;

	// State registers, updated on each accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pos_q  <= '0;
			mode_q <= b64d_pkg::MODE_NORMAL;
			held_q <= '0;
		end else if (accept) begin
			acc_q  <= acc_d;
			pos_q  <= pos_d;
			mode_q <= mode_d;
			held_q <= held_d;
		end
	end

endmodule

// File: sv/b64d_queue.sv
// ============================================================================
// b64d_queue
// Short first-in first-out queue of result groups between front and back.
// ============================================================================
module b64d_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64d_pkg::group_t push_group,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output b64d_pkg::group_t head_group
);

	b64d_pkg::group_t entry_q [b64d_pkg::QUEUE_DEPTH];

	logic [b64d_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [b64d_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [b64d_pkg::QUEUE_AW:0]   fill_q;

	assign full       = (fill_q == (b64d_pkg::QUEUE_AW+1)'(b64d_pkg::QUEUE_DEPTH));
	assign not_empty  = (fill_q != '0);
	assign head_group = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_group;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/b64d_back.sv
// ============================================================================
// b64d_back
// Sends the results of the group at the head of the queue one per transfer
// and releases the entry after its last result.
// ============================================================================
module b64d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             not_empty,
	input  b64d_pkg::group_t head_group,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output b64d_pkg::out_t   out_data
);

	logic [1:0] idx_q;
	logic       group_end;
	logic       xfer;

	assign out_valid = not_empty;
	assign xfer      = out_valid && out_ready;
	assign group_end = (idx_q == head_group.count - 2'd1);
	assign pop       = xfer && group_end;

	// Result at the current position of the head group.
	always_comb begin
		out_data.data_byte     = head_group.data[idx_q];
		out_data.end_of_output = group_end && head_group.last;
		out_data.status        = head_group.status;
	end

	// Position within the head group.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (xfer) begin
			idx_q <= group_end ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// File: sv/base64_stream_decoder.sv
// ============================================================================
// base64_stream_decoder
// Streaming base64 decoder, one character in and one byte out per transfer.
// ============================================================================
// Usage:
// The input channel takes one character per transfer, with final_symbol set
// on the last character of a stream. The output channel gives one result per
// transfer: a decoded byte, or a single error result with a nonzero status.
// end_of_output marks the last result of a stream, errors included.
// A character's results enter the queue as one group when it is accepted.
// Input takes one character a cycle unless the queue is full; output gives
// one result a cycle while out_ready is high, so three bytes from each group
// of four characters leave well within the input's pace.
// A four-entry queue of result groups lies between the character decoder and
// the output serializer. When the receiver stalls, the queue fills and
// in_ready drops only once all four entries are taken; the decoder state is
// untouched while no character is accepted.
// Reset clears the decoder state, the queue and the output position; the
// block is ready for characters as soon as reset is released.
// ============================================================================
module base64_stream_decoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  b64d_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output b64d_pkg::out_t out_data
);

	logic             push;
	logic             pop;
	logic             full;
	logic             not_empty;
	b64d_pkg::group_t push_group;
	b64d_pkg::group_t head_group;

	// Character decoder and stream state.
	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push       (push),
		.push_group (push_group),
		.queue_full (full)
	);

	// Queue of result groups.
	b64d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head_group (head_group)
	);

	// Output serializer.
	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (not_empty),
		.head_group (head_group),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Testbench for base64_stream_decoder. It drives a short table of directed
// characters and then random streams, most of them well formed, over the
// valid/ready channels. The sender idles in bursts and the receiver stalls on
// a rotating pattern, with one long hold-off that fills the result queue.
// Every result transfer is checked against the table or a decoder predictor.
// ============================================================================
module tb;

	localparam int          RANDOM_CHARS = 170;
	localparam int          HOLD_CYCLES  = 60;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam logic [7:0]  PAD_SYM      = 8'h3D;

	// Expected results that can be read off directly.
	localparam b64d_pkg::out_t RES_FF      = '{8'hFF, 1'b0, b64d_pkg::ST_OK};
	localparam b64d_pkg::out_t RES_00      = '{8'h00, 1'b0, b64d_pkg::ST_OK};
	localparam b64d_pkg::out_t RES_00_END  = '{8'h00, 1'b1, b64d_pkg::ST_OK};
	localparam b64d_pkg::out_t RES_BAD_LEN = '{8'h00, 1'b1, b64d_pkg::ST_BAD_LEN};
	localparam b64d_pkg::out_t RES_BAD_CHR = '{8'h00, 1'b1, b64d_pkg::ST_BAD_CHAR};
	localparam b64d_pkg::out_t RES_BAD_PAD = '{8'h00, 1'b1, b64d_pkg::ST_BAD_PAD};

	// One row of the directed table; nwant of zero leaves it to the predictor.
	typedef struct packed {
		b64d_pkg::in_t        item;
		logic [1:0]           nwant;
		b64d_pkg::out_t [2:0] want;
	} row_t;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	b64d_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	b64d_pkg::out_t out_data;

	// Typed expectation travelling with the character on the input channel.
	logic [1:0]           stim_nwant;
	b64d_pkg::out_t [2:0] stim_want;

	logic       hold_off;
	bit         rand_phase;
	int         burst_left = 0;
	logic [7:0] rx_pat;
	int         rx_left = 0;

	// Predictor state of the decoder.
	logic [17:0]    acc;
	logic [1:0]     qpos;
	logic [1:0]     dec_mode;
	logic [7:0]     held;
	logic [6:0]     char_class [256];
	b64d_pkg::out_t fresh[$];
	b64d_pkg::out_t pending_results[$];

	row_t          dir_rows[$];
	b64d_pkg::in_t char_queue[$];
	string         alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	int mismatches  = 0;
	int chars_in    = 0;
	int live_chars  = 0;
	int results_out = 0;
	int in_stalls   = 0;
	int cycles      = 0;
	int status_seen [4] = '{0, 0, 0, 0};

	base64_stream_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Clock with a 20 ns period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void reset_decoder();
		acc      = '0;
		qpos     = '0;
		dec_mode = b64d_pkg::MODE_NORMAL;
		held     = '0;
	endfunction

	function automatic void emit(input logic [7:0] b, input logic eoo, input logic [1:0] st);
		b64d_pkg::out_t r;
		r = '{b, eoo, st};
		fresh = {fresh, r};
	endfunction

	// An error gives one result; a stream that goes on is then dropped.
	function automatic void flag_error(input logic [1:0] st, input logic fin);
		emit(8'h00, 1'b1, st);
		reset_decoder();
		if (!fin) begin
			dec_mode = b64d_pkg::MODE_DROP;
		end
	endfunction

	// Advances the predicted decoder by one character and collects its results.
	function automatic void decode_char(input b64d_pkg::in_t d);
		logic [6:0]  cls;
		logic [23:0] word;
		fresh.delete();
		cls = char_class[d.symbol];
		if (dec_mode == b64d_pkg::MODE_DROP) begin
			if (d.final_symbol) begin
				reset_decoder();
			end
		end else if (dec_mode == b64d_pkg::MODE_AWAIT_LAST) begin
			// The character after a third-position pad is not looked at.
			if (d.final_symbol) begin
				emit(held, 1'b1, b64d_pkg::ST_OK);
				reset_decoder();
			end else begin
				flag_error(b64d_pkg::ST_BAD_PAD, 1'b0);
			end
		end else if (d.final_symbol && qpos != 2'd3) begin
			// Length is judged before the character itself.
			flag_error(b64d_pkg::ST_BAD_LEN, 1'b1);
		end else if (cls == b64d_pkg::CLS_INVALID) begin
			flag_error(b64d_pkg::ST_BAD_CHAR, d.final_symbol);
		end else if (cls == b64d_pkg::CLS_PAD) begin
			if (qpos == 2'd2) begin
				held     = acc[11:4];
				acc      = '0;
				qpos     = '0;
				dec_mode = b64d_pkg::MODE_AWAIT_LAST;
			end else if (qpos == 2'd3 && d.final_symbol) begin
				emit(acc[17:10], 1'b0, b64d_pkg::ST_OK);
				emit(acc[9:2], 1'b1, b64d_pkg::ST_OK);
				reset_decoder();
			end else begin
				flag_error(b64d_pkg::ST_BAD_PAD, d.final_symbol);
			end
		end else if (qpos == 2'd3) begin
			word = {acc, cls[5:0]};
			emit(word[23:16], 1'b0, b64d_pkg::ST_OK);
			emit(word[15:8], 1'b0, b64d_pkg::ST_OK);
			emit(word[7:0], d.final_symbol, b64d_pkg::ST_OK);
			reset_decoder();
		end else begin
			acc  = {acc[11:0], cls[5:0]};
			qpos = qpos + 2'd1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic add_row(input logic [7:0] sym, input logic fin, input logic [1:0] n,
			input b64d_pkg::out_t w0 = '0, input b64d_pkg::out_t w1 = '0,
			input b64d_pkg::out_t w2 = '0);
		row_t r;
		r.item  = '{sym, fin};
		r.nwant = n;
		r.want  = {w2, w1, w0};
		dir_rows = {dir_rows, r};
	endtask

	function automatic logic [7:0] rand_letter();
		return alpha[$urandom_range(0, 63)];
	endfunction

	function automatic logic [7:0] rand_invalid();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (char_class[b] != b64d_pkg::CLS_INVALID);
		return b;
	endfunction

	function automatic void queue_char(input logic [7:0] sym, input logic fin);
		b64d_pkg::in_t c;
		c = '{sym, fin};
		char_queue = {char_queue, c};
	endfunction

	// Builds one random stream: mostly well formed, some broken, some noise.
	function automatic void gen_stream();
		int kind;
		int nq;
		int p;
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(0, 7)) begin
				queue_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
			end
			queue_char(8'($urandom_range(0, 255)), 1'b1);
			return;
		end
		nq = $urandom_range(0, 3);
		repeat (nq * 4) begin
			queue_char(rand_letter(), 1'b0);
		end
		if (kind < 6) begin
			case ($urandom_range(0, 2))
				0: begin
					repeat (3) queue_char(rand_letter(), 1'b0);
					queue_char(rand_letter(), 1'b1);
				end
				1: begin
					repeat (3) queue_char(rand_letter(), 1'b0);
					queue_char(PAD_SYM, 1'b1);
				end
				default: begin
					repeat (2) queue_char(rand_letter(), 1'b0);
					queue_char(PAD_SYM, 1'b0);
					queue_char(8'($urandom_range(0, 255)), 1'b1);
				end
			endcase
		end else begin
			p = $urandom_range(0, 3);
			repeat (p) queue_char(rand_letter(), 1'b0);
			case ($urandom_range(0, 3))
				0: queue_char(rand_invalid(), 1'($urandom_range(0, 1)));
				1: queue_char(PAD_SYM, 1'($urandom_range(0, 1)));
				2: queue_char(rand_letter(), 1'b1);
				default: begin
					queue_char(PAD_SYM, 1'b0);
					queue_char(rand_letter(), 1'b0);
				end
			endcase
			repeat ($urandom_range(0, 3)) queue_char(8'($urandom_range(0, 255)), 1'b0);
			queue_char(8'($urandom_range(0, 255)), 1'b1);
		end
	endfunction

	// Offers one character and waits for its transfer, idling between bursts.
	task automatic send_char(input b64d_pkg::in_t c, input logic [1:0] n,
			input b64d_pkg::out_t [2:0] w);
		if (burst_left == 0 && !hold_off) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
			                                          : $urandom_range(1, 8);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		in_data    <= c;
		stim_nwant <= n;
		stim_want  <= w;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	task automatic report(input string what);
		mismatches++;
		$display("MISMATCH at cycle %0d: %s", cycles, what);
	endtask

	// ------------------------------------------------------------------
	// Receiver: stalls on a rotating pattern, renewed at random when rx_left runs out.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_left = 32;
			rx_pat  = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
			if (rx_pat == 8'h00) begin
				rx_pat = 8'h01;
			end
		end
		out_ready <= rx_pat[0] && !hold_off;
		rx_pat  = {rx_pat[0], rx_pat[7:1]};
		rx_left--;
	end

	// Long hold-off at the start of the random part, so the queue fills up.
	initial begin
		hold_off = 1'b0;
		wait (rand_phase);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on each input transfer, checks each output transfer.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		b64d_pkg::out_t want;
		if (arst_n) begin
			if (in_valid && !in_ready) begin
				in_stalls++;
			end
			if (in_valid && in_ready) begin
				chars_in++;
				if (dec_mode != b64d_pkg::MODE_DROP) begin
					live_chars++;
				end
				decode_char(in_data);
				if (stim_nwant != 2'd0) begin
					for (int k = 0; k < stim_nwant; k++) begin
						pending_results = {pending_results, stim_want[k]};
					end
				end else begin
					pending_results = {pending_results, fresh};
				end
			end
			if (out_valid && out_ready) begin
				results_out++;
				status_seen[out_data.status]++;
				if (pending_results.size() == 0) begin
					report($sformatf("result %0d with nothing expected: %h", results_out,
						out_data));
				end else begin
					want = pending_results.pop_front();
					if (out_data.data_byte !== want.data_byte)
						report($sformatf("result %0d data_byte %h, expected %h",
							results_out, out_data.data_byte, want.data_byte));
					if (out_data.end_of_output !== want.end_of_output)
						report($sformatf("result %0d end_of_output %b, expected %b",
							results_out, out_data.end_of_output, want.end_of_output));
					if (out_data.status !== want.status)
						report($sformatf("result %0d status %0d, expected %0d",
							results_out, out_data.status, want.status));
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results still expected", pending_results.size());
			$display("tb: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int target;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_ready  = 1'b0;
		stim_nwant = '0;
		stim_want  = '0;
		rand_phase = 1'b0;

		// Character classes: alphabet values, pad, everything else invalid.
		for (int i = 0; i < 256; i++) begin
			char_class[i] = b64d_pkg::CLS_INVALID;
		end
		for (int i = 0; i < 64; i++) begin
			char_class[alpha[i]] = 7'(i);
		end
		char_class[PAD_SYM] = b64d_pkg::CLS_PAD;
		reset_decoder();

		// Largest and smallest full quanta.
		add_row("/", 1'b0, 2'd0);
		add_row("/", 1'b0, 2'd0);
		add_row("/", 1'b0, 2'd0);
		add_row("/", 1'b0, 2'd3, RES_FF, RES_FF, RES_FF);
		add_row("A", 1'b0, 2'd0);
		add_row("A", 1'b0, 2'd0);
		add_row("A", 1'b0, 2'd0);
		add_row("A", 1'b1, 2'd3, RES_00, RES_00, RES_00_END);
		// Last character in the first position.
		add_row("A", 1'b1, 2'd1, RES_BAD_LEN);
		// Invalid character, then a dropped run closed by the last flag.
		add_row("*", 1'b0, 2'd1, RES_BAD_CHR);
		add_row("=", 1'b0, 2'd0);
		add_row("z", 1'b1, 2'd0);
		// Pad in the first position.
		add_row("=", 1'b0, 2'd1, RES_BAD_PAD);
		add_row("9", 1'b1, 2'd0);
		// Pad in the fourth position on the last character.
		add_row("T", 1'b0, 2'd0);
		add_row("W", 1'b0, 2'd0);
		add_row("E", 1'b0, 2'd0);
		add_row("=", 1'b1, 2'd0);
		// Pad in the third position; the closing character is not checked.
		add_row("T", 1'b0, 2'd0);
		add_row("Q", 1'b0, 2'd0);
		add_row("=", 1'b0, 2'd0);
		add_row(8'hFF, 1'b1, 2'd0);
		// Third-position pad followed by a character that is not the last.
		add_row("a", 1'b0, 2'd0);
		add_row("b", 1'b0, 2'd0);
		add_row("=", 1'b0, 2'd0);
		add_row("c", 1'b0, 2'd1, RES_BAD_PAD);
		add_row("q", 1'b1, 2'd0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table.
		foreach (dir_rows[i]) begin
			send_char(dir_rows[i].item, dir_rows[i].nwant, dir_rows[i].want);
		end

		// Random streams.
		rand_phase = 1'b1;
		target = live_chars + RANDOM_CHARS;
		while (live_chars < target) begin
			gen_stream();
			while (char_queue.size() != 0) begin
				send_char(char_queue.pop_front(), 2'd0, '0);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain the outstanding results, then watch for strays.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d characters sent, %0d outside drop runs, %0d results checked",
			chars_in, live_chars, results_out);
		$display("summary: error results char/pad/length %0d/%0d/%0d, %0d input stall cycles",
			status_seen[b64d_pkg::ST_BAD_CHAR], status_seen[b64d_pkg::ST_BAD_PAD],
			status_seen[b64d_pkg::ST_BAD_LEN], in_stalls);
		if (mismatches == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder.sv
dv/tb.sv
